@@ hdl/nsf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared types, constants and the CRC-32 byte step of the notify section
// filter.
// ----------------------------------------------------------------------------
package nsf_pkg;

   localparam int MAX_SECTION_BYTES = 4096;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int LEN_W   = 12;           // section length field width
   localparam int IDX_W   = 12;           // byte position within a section
   localparam int SUM_W   = LEN_W + 1;    // length plus header, no overflow
   localparam int TYPE_W  = 8;
   localparam int DONE_W  = 12;           // entries completed in a section
   localparam int OFF_W   = 3;            // position within a 5-byte entry

   localparam logic [WORD_W-1:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [IDX_W-1:0] HDR_BYTES     = 12'd3;
   localparam logic [IDX_W-1:0] LEN_HI_BYTE   = 12'd1;
   localparam logic [IDX_W-1:0] LEN_LO_BYTE   = 12'd2;
   localparam logic [IDX_W-1:0] CID_FIRST     = 12'd5;
   localparam logic [IDX_W-1:0] CID_LAST      = 12'd8;
   localparam logic [IDX_W-1:0] TYPE_BYTE     = 12'd10;
   localparam logic [IDX_W-1:0] COUNT_FIRST   = 12'd12;
   localparam logic [IDX_W-1:0] COUNT_LAST    = 12'd15;
   localparam logic [IDX_W-1:0] ENTRY_FIRST   = 12'd16;
   localparam logic [LEN_W-1:0] MIN_LENGTH    = 12'd4;
   localparam logic [OFF_W-1:0] ENTRY_ID_LAST = 3'd3;
   localparam logic [OFF_W-1:0] ENTRY_END     = 3'd4;
   localparam logic [TYPE_W-1:0] TYPE_ANY_MAX = 8'd1;   // types 0,1: everyone
   localparam logic [TYPE_W-1:0] TYPE_INC_MAX = 8'd3;   // types 2,3: id list

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified section byte, front to back.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              clear;        // first byte of a new section
      logic              crc_upd;
      logic              cap_content;
      logic              cap_type;
      logic              cap_count;
      logic              entry;        // byte inside the entry list
      logic              entry_id_end; // last id byte of an entry
      logic              entry_end;    // last byte of an entry
      logic              recv;         // trailing CRC byte
      logic              last;         // final CRC byte, produces a result
   } nsf_cmd_type;

   typedef struct packed {
      logic              crc_ok;
      logic              section_match;
      logic [WORD_W-1:0] content_id;
      logic              match_seen;
   } nsf_rsp_type;

   function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [WORD_W-1:0] c;
      c = crc ^ {b, {(WORD_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[WORD_W-1]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ hdl/notify_section_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// notify_section_filter
// Byte-serial filter for broadcast notify private sections with CRC-32 check.
// ----------------------------------------------------------------------------
// Takes one section byte per clock (push/full), start_of_section marking byte
// 0. The 12-bit length is read from bytes 1-2; sections shorter than 4 or
// longer than MAX_SECTION_BYTES are dropped silently. An MPEG-2 CRC-32 runs
// over every byte ahead of the trailing CRC field. Content id (bytes 5..8),
// notify type (byte 10) and entry count (bytes 12..15) are captured, and the
// 5-byte entries from byte 16 on are searched for csr_machine_id. One result
// comes out (empty/pop) after the last CRC byte. Throughput is one byte per
// cycle while the back end is not held: the front end tags each byte
// combinationally, and the back end folds one byte per cycle into the CRC
// (an unrolled 8-step shift-and-xor update). A four-entry command queue
// between them plus the result register let the input keep flowing while a
// result waits; only a section end that finds the result register still
// occupied holds the back end. The last CRC byte passes through the command
// queue, behind any bytes ahead of it, and then into the result register.
// csr_machine_id is to be written only while no section is in flight.
// ----------------------------------------------------------------------------
module notify_section_filter (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // byte input
   input  wire logic                       push,
   output logic                            full,
   input  wire logic [nsf_pkg::BYTE_W-1:0] req_section_byte,
   input  wire logic                       req_start_of_section,
   // result output
   output logic                            empty,
   input  wire logic                       pop,
   output logic                            rsp_crc_ok,
   output logic                            rsp_section_match,
   output logic [nsf_pkg::WORD_W-1:0]      rsp_content_id,
   output logic                            rsp_match_seen,
   // machine id register
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [nsf_pkg::WORD_W-1:0] csr_machine_id
);
   import nsf_pkg::*;

   logic [WORD_W-1:0] machine_id_ff;

   nsf_cmd_type q_wr_data, q_rd_data;
   logic        q_wr_en, q_full, q_rd_en, q_valid;
   logic        rsp_valid;
   nsf_rsp_type rsp_data;

   // Register write is always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         machine_id_ff <= '0;
      end else if (csr_valid) begin
         machine_id_ff <= csr_machine_id;
      end
   end

   // Front: tracks position in the section and classifies every byte.
   nsf_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_push             (push),
      .req_full             (full),
      .req_section_byte     (req_section_byte),
      .req_start_of_section (req_start_of_section),
      .cmd_push             (q_wr_en),
      .cmd_data             (q_wr_data),
      .cmd_full             (q_full)
   );

   // Decoupling queue; front and back stall independently.
   nsf_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_data (q_wr_data),
      .full    (q_full),
      .rd_en   (q_rd_en),
      .rd_data (q_rd_data),
      .valid   (q_valid)
   );

   // Back: CRC, field capture, entry scan, result register.
   nsf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .machine_id (machine_id_ff),
      .cmd_valid  (q_valid),
      .cmd_data   (q_rd_data),
      .cmd_pop    (q_rd_en),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_take   (pop)
   );

   assign empty             = !rsp_valid;
   assign rsp_crc_ok        = rsp_data.crc_ok;
   assign rsp_section_match = rsp_data.section_match;
   assign rsp_content_id    = rsp_data.content_id;
   assign rsp_match_seen    = rsp_data.match_seen;

endmodule
`default_nettype wire

@@ hdl/nsf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nsf_front
// Byte tracker: follows position and length of the open section and tags
// each byte with the work the back end has to do.
// ----------------------------------------------------------------------------
module nsf_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [nsf_pkg::BYTE_W-1:0]  req_section_byte,
   input  wire logic                        req_start_of_section,
   output logic                             cmd_push,
   output nsf_pkg::nsf_cmd_type             cmd_data,
   input  wire logic                        cmd_full
);
   import nsf_pkg::*;

   logic             in_sec_ff, in_sec_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [OFF_W-1:0] off_ff, off_in;

   logic             start;
   logic             active;
   logic [IDX_W-1:0] i;
   logic [LEN_W-1:0] len;
   logic [OFF_W-1:0] off;
   logic [LEN_W-1:0] len_new;
   logic             accept;
   nsf_cmd_type      cmd;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign start    = req_start_of_section;

   always_comb begin
      active  = start || in_sec_ff;
      i       = start ? '0 : idx_ff;
      len     = start ? '0 : len_ff;
      off     = start ? '0 : off_ff;
      len_new = {len[LEN_W-1:BYTE_W], req_section_byte};

      in_sec_in = active;
      idx_in    = i;
      len_in    = len;
      off_in    = off;
      cmd       = '0;
      cmd.data  = req_section_byte;
      cmd.clear = start;

      if (active) begin
         if (i < HDR_BYTES) begin
            cmd.crc_upd = 1'b1;
            if (i == LEN_HI_BYTE) begin
               len_in = {req_section_byte[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            end
            if (i == LEN_LO_BYTE) begin
               len_in = len_new;
               if (len_new < MIN_LENGTH ||
                   ({1'b0, len_new} + SUM_W'(3)) > SUM_W'(MAX_SECTION_BYTES)) begin
                  in_sec_in = 1'b0;
               end
            end
            idx_in = i + 1'b1;
         end else begin
            cmd.cap_content = (i >= CID_FIRST) && (i <= CID_LAST);
            cmd.cap_type    = (i == TYPE_BYTE);
            cmd.cap_count   = (i >= COUNT_FIRST) && (i <= COUNT_LAST);
            if (i < len - 1'b1) begin
               cmd.crc_upd = 1'b1;
               if (i >= ENTRY_FIRST) begin
                  cmd.entry        = 1'b1;
                  cmd.entry_id_end = (off == ENTRY_ID_LAST);
                  cmd.entry_end    = (off == ENTRY_END);
                  off_in           = (off == ENTRY_END) ? '0 : off + 1'b1;
               end
               idx_in = i + 1'b1;
            end else begin
               cmd.recv = 1'b1;
               if (i == len + LEN_W'(2)) begin
                  cmd.last  = 1'b1;
                  in_sec_in = 1'b0;
                  idx_in    = '0;
               end else begin
                  idx_in = i + 1'b1;
               end
            end
         end
      end
   end

   assign cmd_push = accept && active;
   assign cmd_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sec_ff <= 1'b0;
         idx_ff    <= '0;
         len_ff    <= '0;
         off_ff    <= '0;
      end else if (accept) begin
         in_sec_ff <= in_sec_in;
         idx_ff    <= idx_in;
         len_ff    <= len_in;
         off_ff    <= off_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/nsf_cmd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nsf_cmd_queue
// Short FIFO of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module nsf_cmd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire nsf_pkg::nsf_cmd_type wr_data,
   output logic                      full,
   input  wire logic                 rd_en,
   output nsf_pkg::nsf_cmd_type      rd_data,
   output logic                      valid
);
   import nsf_pkg::*;

   nsf_cmd_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              do_wr, do_rd;

   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && valid;

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

@@ hdl/nsf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nsf_back
// Section engine: CRC, header fields, entry scan and the result register.
// ----------------------------------------------------------------------------
module nsf_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [nsf_pkg::WORD_W-1:0] machine_id,
   input  wire logic                       cmd_valid,
   input  wire nsf_pkg::nsf_cmd_type       cmd_data,
   output logic                            cmd_pop,
   output logic                            rsp_valid,
   output nsf_pkg::nsf_rsp_type            rsp_data,
   input  wire logic                       rsp_take
);
   import nsf_pkg::*;

   logic [WORD_W-1:0] crc_ff, crc_in;
   logic [WORD_W-1:0] recv_ff, recv_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [WORD_W-1:0] cid_ff, cid_in;
   logic [WORD_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [DONE_W-1:0] done_ff, done_in;
   logic              found_ff, found_in;
   logic              sticky_ff, sticky_in;
   logic              rsp_valid_ff;
   nsf_rsp_type       rsp_ff, rsp_in;

   logic              go;
   logic              ok, match;

   // A final byte waits only while the previous result is still held.
   assign cmd_pop = cmd_valid && (!cmd_data.last || !rsp_valid_ff || rsp_take);
   assign go      = cmd_pop;

   always_comb begin
      crc_in   = cmd_data.clear ? CRC_INIT : crc_ff;
      recv_in  = cmd_data.clear ? '0 : recv_ff;
      type_in  = cmd_data.clear ? '0 : type_ff;
      cid_in   = cmd_data.clear ? '0 : cid_ff;
      count_in = cmd_data.clear ? '0 : count_ff;
      shift_in = cmd_data.clear ? '0 : shift_ff;
      done_in  = cmd_data.clear ? '0 : done_ff;
      found_in = cmd_data.clear ? 1'b0 : found_ff;
      sticky_in = sticky_ff;

      ok    = 1'b0;
      match = 1'b0;

      if (cmd_data.cap_content) cid_in   = {cid_in[WORD_W-BYTE_W-1:0], cmd_data.data};
      if (cmd_data.cap_type)    type_in  = cmd_data.data;
      if (cmd_data.cap_count)   count_in = {count_in[WORD_W-BYTE_W-1:0], cmd_data.data};
      if (cmd_data.recv)        recv_in  = {recv_in[WORD_W-BYTE_W-1:0], cmd_data.data};

      if (cmd_data.entry) begin
         shift_in = {shift_in[WORD_W-BYTE_W-1:0], cmd_data.data};
         if (cmd_data.entry_id_end && (WORD_W'(done_in) < count_in) &&
             (shift_in == machine_id)) begin
            found_in = 1'b1;
         end
         if (cmd_data.entry_end) begin
            done_in = done_in + 1'b1;
         end
      end

      // CRC is compared before this byte would be folded in; CRC bytes never are.
      if (cmd_data.last) begin
         ok = (crc_in == recv_in);
         if (ok) begin
            if (type_in <= TYPE_ANY_MAX || machine_id == '0) begin
               match = 1'b1;
            end else if (type_in <= TYPE_INC_MAX) begin
               match = found_in;
            end else begin
               match = !found_in;
            end
         end
         if (match) begin
            sticky_in = 1'b1;
         end
      end

      if (cmd_data.crc_upd) begin
         crc_in = crc_byte(crc_in, cmd_data.data);
      end

      rsp_in.crc_ok        = ok;
      rsp_in.section_match = match;
      rsp_in.content_id    = ok ? cid_in : '0;
      rsp_in.match_seen    = sticky_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         recv_ff      <= '0;
         type_ff      <= '0;
         cid_ff       <= '0;
         count_ff     <= '0;
         shift_ff     <= '0;
         done_ff      <= '0;
         found_ff     <= 1'b0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            crc_ff    <= crc_in;
            recv_ff   <= recv_in;
            type_ff   <= type_in;
            cid_ff    <= cid_in;
            count_ff  <= count_in;
            shift_ff  <= shift_in;
            done_ff   <= done_in;
            found_ff  <= found_in;
            sticky_ff <= sticky_in;
         end
         if (go && cmd_data.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go && cmd_data.last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ tb/notify_section_filter_test.sv @@
// ----------------------------------------------------------------------------
// notify_section_filter_test
// Self-checking bench for the byte-serial notify section filter.
// ----------------------------------------------------------------------------
// Sections are built here: length, content id, notify type, entry count and
// an entry list are laid out, the MPEG-2 CRC-32 is appended, and the bytes
// are pushed one transfer at a time. A bit-level tracker of the filter
// follows every accepted byte and queues the verdict each complete section
// should produce. A monitor pops verdicts and compares every field. The run
// covers header corner cases, each notify type against the id list, entries
// that run into the CRC, a section of the longest legal length abandoned part
// way, a long output hold-off that backs the input up, and random traffic
// under several machine ids.
// ----------------------------------------------------------------------------
module notify_section_filter_test;
   import nsf_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 12;     // command queue plus result tail
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_PCT     = 17;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_BYTES  = 60;     // per random phase, plus overshoot

   // DUT ports
   logic                clock;
   logic                reset;
   logic                push;
   logic                full;
   logic [BYTE_W-1:0]   req_section_byte;
   logic                req_start_of_section;
   logic                empty;
   logic                pop;
   logic                rsp_crc_ok;
   logic                rsp_section_match;
   logic [WORD_W-1:0]   rsp_content_id;
   logic                rsp_match_seen;
   logic                csr_valid;
   logic                csr_ready;
   logic [WORD_W-1:0]   csr_machine_id;

   // Tracker state: mirrors the filter one accepted byte at a time
   logic [WORD_W-1:0]   rx_machine_id;
   logic [IDX_W-1:0]    sec_pos;
   logic [LEN_W-1:0]    sec_len;
   logic [WORD_W-1:0]   crc_acc;
   logic [WORD_W-1:0]   crc_rx;
   logic [WORD_W-1:0]   cid_acc;
   logic [TYPE_W-1:0]   kind_acc;
   logic [WORD_W-1:0]   count_acc;
   logic [WORD_W-1:0]   entry_win;
   logic [WORD_W-1:0]   entries_seen;
   logic                id_hit;
   logic                sticky_hit;
   logic                sec_open;

   nsf_rsp_type         expected_verdicts[$];
   nsf_rsp_type         want;

   // Shared knobs between the stimulus and the result side
   bit                  no_gaps;
   bit                  hold_request;

   int                  cycle_count;
   int                  error_count;
   int                  results_checked;
   int                  bytes_sent;
   int                  stray_bytes;
   int                  sections_sent;
   int                  stall_cycles;
   int                  config_writes;
   int                  holds_done;

   notify_section_filter u_top (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_section_byte     (req_section_byte),
      .req_start_of_section (req_start_of_section),
      .empty                (empty),
      .pop                  (pop),
      .rsp_crc_ok           (rsp_crc_ok),
      .rsp_section_match    (rsp_section_match),
      .rsp_content_id       (rsp_content_id),
      .rsp_match_seen       (rsp_match_seen),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_machine_id       (csr_machine_id)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: any hang in a handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d verdicts still pending",
                  cycle_count, expected_verdicts.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tracker
   // ---------------------------------------------------------------------

   // MPEG-2 CRC-32, one byte, msb first, no reflection.
   function automatic logic [WORD_W-1:0] crc32_mpeg2_update(input logic [WORD_W-1:0] crc,
                                                            input logic [BYTE_W-1:0] data);
      logic [WORD_W-1:0] acc;
      logic              fb;
      acc = crc;
      for (int k = BYTE_W - 1; k >= 0; k--) begin
         fb  = acc[WORD_W-1] ^ data[k];
         acc = {acc[WORD_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return acc;
   endfunction

   task automatic clear_section_model;
      sec_pos      = '0;
      sec_len      = '0;
      crc_acc      = CRC_INIT;
      crc_rx       = '0;
      cid_acc      = '0;
      kind_acc     = '0;
      count_acc    = '0;
      entry_win    = '0;
      entries_seen = '0;
      id_hit       = 1'b0;
   endtask

   // Advance the tracker by one accepted byte; a finished section queues
   // its verdict.
   task automatic track_section_byte(input logic [BYTE_W-1:0] b, input logic sos);
      int          i;
      int          crc_first;
      int          off;
      logic        ok;
      logic        hit;
      nsf_rsp_type verdict;
      if (sos) begin
         clear_section_model();
         sec_open = 1'b1;
      end
      if (!sec_open) begin
         return;     // stray byte, nothing open
      end
      i = int'(sec_pos);
      if (i < 3) begin
         crc_acc = crc32_mpeg2_update(crc_acc, b);
         if (i == 1) begin
            sec_len = {b[3:0], 8'h00};
         end
         if (i == 2) begin
            sec_len[7:0] = b;
            // too short for a CRC, or longer than the section buffer
            if (sec_len < MIN_LENGTH || int'(sec_len) + 3 > MAX_SECTION_BYTES) begin
               sec_open = 1'b0;
               return;
            end
         end
         sec_pos = sec_pos + 1'b1;
         return;
      end
      crc_first = int'(sec_len) - 1;
      // header capture runs regardless of where the CRC starts
      if (i >= 5 && i <= 8) begin
         cid_acc = {cid_acc[23:0], b};
      end
      if (i == 10) begin
         kind_acc = b;
      end
      if (i >= 12 && i <= 15) begin
         count_acc = {count_acc[23:0], b};
      end
      if (i < crc_first) begin
         crc_acc = crc32_mpeg2_update(crc_acc, b);
         if (i >= 16) begin
            off       = (i - 16) % 5;
            entry_win = {entry_win[23:0], b};
            if (off == 3 && entries_seen < count_acc && entry_win == rx_machine_id) begin
               id_hit = 1'b1;
            end
            if (off == 4) begin
               entries_seen++;
            end
         end
         sec_pos = sec_pos + 1'b1;
         return;
      end
      crc_rx = {crc_rx[23:0], b};
      if (i < int'(sec_len) + 2) begin
         sec_pos = sec_pos + 1'b1;
         return;
      end
      // last CRC byte
      ok  = (crc_acc == crc_rx);
      hit = 1'b0;
      if (ok) begin
         if (kind_acc <= TYPE_ANY_MAX || rx_machine_id == '0) begin
            hit = 1'b1;
         end else if (kind_acc <= TYPE_INC_MAX) begin
            hit = id_hit;
         end else begin
            hit = !id_hit;
         end
      end
      if (hit) begin
         sticky_hit = 1'b1;
      end
      verdict.crc_ok        = ok;
      verdict.section_match = hit;
      verdict.content_id    = ok ? cid_acc : '0;
      verdict.match_seen    = sticky_hit;
      expected_verdicts.push_back(verdict);
      sec_open = 1'b0;
      sec_pos  = '0;
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   task automatic flag_error(input string what, input logic [WORD_W-1:0] want_v,
                             input logic [WORD_W-1:0] got_v);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s expected %h, got %h", $time, what, want_v, got_v);
      end
   endtask

   // Pop driver. A hold request parks pop low for a long stretch so the
   // result register and the command queue fill and full rises.
   initial begin
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            pop <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               @(posedge clock);
            end
            holds_done++;
         end
         pop <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Monitor: a transfer on the result side is checked against the oldest
   // pending verdict.
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_verdicts.size() == 0) begin
            flag_error("unexpected result, crc_ok", '0, WORD_W'(rsp_crc_ok));
         end else begin
            want = expected_verdicts.pop_front();
            results_checked++;
            if (rsp_crc_ok !== want.crc_ok) begin
               flag_error("crc_ok", WORD_W'(want.crc_ok), WORD_W'(rsp_crc_ok));
            end
            if (rsp_section_match !== want.section_match) begin
               flag_error("section_match", WORD_W'(want.section_match),
                          WORD_W'(rsp_section_match));
            end
            if (rsp_content_id !== want.content_id) begin
               flag_error("content_id", want.content_id, rsp_content_id);
            end
            if (rsp_match_seen !== want.match_seen) begin
               flag_error("match_seen", WORD_W'(want.match_seen), WORD_W'(rsp_match_seen));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // One byte transfer. Random gaps drop push first; push otherwise stays
   // high so back-to-back bytes run at full rate.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic sos);
      while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push                 <= 1'b1;
      req_section_byte     <= b;
      req_start_of_section <= sos;
      @(posedge clock);
      while (full) begin
         stall_cycles++;
         @(posedge clock);
      end
      track_section_byte(b, sos);
      bytes_sent++;
   endtask

   // Wait until every verdict is in, then let bytes that give no result
   // (dropped headers) clear the pipeline.
   task automatic drain_results;
      push <= 1'b0;
      @(posedge clock);
      while (expected_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_machine_id(input logic [WORD_W-1:0] id);
      drain_results();
      csr_valid      <= 1'b1;
      csr_machine_id <= id;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid     <= 1'b0;
      rx_machine_id  = id;
      config_writes++;
   endtask

   // Lay out a section of length field len, append its CRC and send it.
   // hit_slot plants the current machine id in that entry (-1: none),
   // corrupt flips one bit past the length bytes, cut >= 0 stops early.
   task automatic send_section(input int len, input logic [WORD_W-1:0] cid,
                               input logic [TYPE_W-1:0] kind,
                               input logic [WORD_W-1:0] count, input int hit_slot,
                               input bit corrupt, input int cut);
      logic [BYTE_W-1:0] body[$];
      logic [BYTE_W-1:0] v;
      logic [WORD_W-1:0] crc;
      logic [LEN_W-1:0]  len_bits;
      int                p;
      int                flip;
      len_bits = LEN_W'(len);
      crc      = CRC_INIT;
      for (p = 0; p < len - 1; p++) begin
         case (p)
            1:              v = {4'($urandom_range(15)), len_bits[11:8]};
            2:              v = len_bits[7:0];
            5, 6, 7, 8:     v = cid[8*(8-p) +: 8];
            10:             v = kind;
            12, 13, 14, 15: v = count[8*(15-p) +: 8];
            default:        v = BYTE_W'($urandom_range(255));
         endcase
         if (p >= 16 && (p - 16) / 5 == hit_slot && (p - 16) % 5 < 4) begin
            v = rx_machine_id[8*(3-(p-16)%5) +: 8];
         end
         body.push_back(v);
         crc = crc32_mpeg2_update(crc, v);
      end
      for (p = 3; p >= 0; p--) begin
         body.push_back(crc[8*p +: 8]);
      end
      if (corrupt) begin
         flip       = $urandom_range(body.size() - 1, 3);
         body[flip] = body[flip] ^ (8'h01 << $urandom_range(7));
      end
      if (cut < 0 || cut > body.size()) begin
         cut = body.size();
      end
      for (p = 0; p < cut; p++) begin
         send_byte(body[p], p == 0);
      end
      sections_sent++;
   endtask

   // Header whose length gets the section dropped, plus trailing bytes the
   // filter must ignore.
   task automatic send_bad_header(input logic [LEN_W-1:0] len, input int strays);
      send_byte(BYTE_W'($urandom_range(255)), 1'b1);
      send_byte({4'($urandom_range(15)), len[11:8]}, 1'b0);
      send_byte(len[7:0], 1'b0);
      repeat (strays) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
   endtask

   // Well-formed section with random content; mostly short, a few longer.
   task automatic random_section(input bit truncate);
      int                r;
      int                len;
      int                n_slots;
      int                hit;
      logic [TYPE_W-1:0] kind;
      logic [WORD_W-1:0] count;
      r = $urandom_range(9);
      if (r == 0) begin
         len = $urandom_range(16, 4);     // header fields run into the CRC
      end else if (r < 8) begin
         len = $urandom_range(60, 17);
      end else begin
         len = $urandom_range(200, 61);
      end
      n_slots = (len - 17) / 5;
      hit     = (n_slots > 0 && $urandom_range(1)) ? $urandom_range(n_slots - 1) : -1;
      case ($urandom_range(9))
         0:       kind = 8'd0;
         1:       kind = 8'd1;
         2, 3:    kind = 8'd2;
         4, 5:    kind = 8'd3;
         6, 7:    kind = 8'd4;
         8:       kind = 8'hFF;
         default: kind = TYPE_W'($urandom_range(255));
      endcase
      case ($urandom_range(5))
         0:       count = '0;
         1:       count = '1;
         2:       count = $urandom;
         default: count = $urandom_range(n_slots + 1);
      endcase
      send_section(len, $urandom, kind, count, hit, $urandom_range(99) < 8,
                   truncate ? $urandom_range(len + 2, 1) : -1);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Header handling with machine id zero: every good CRC matches.
   task automatic test_section_rules;
      write_machine_id('0);
      send_byte(8'h00, 1'b0);                       // nothing open, ignored
      send_byte(8'hFF, 1'b0);
      send_bad_header(12'd3, 1);                    // too short
      send_bad_header(12'd0, 0);
      send_bad_header(12'd4094, 0);                 // one past the buffer
      send_bad_header(12'd4095, 1);
      send_section(4, '1, 8'hFF, '1, -1, 0, -1);    // content id partly from CRC bytes
      send_section(13, '0, 8'd2, '0, -1, 0, -1);    // count taken from CRC bytes
      send_section(40, $urandom, 8'd3, 32'd2, 0, 0, 20);   // abandoned mid-way
      send_section(22, '1, 8'd4, 32'd1, 0, 0, -1);
      send_section(24, 32'h1234_5678, 8'd0, '0, -1, 1, -1);  // bad CRC
   endtask

   // Notify type against the entry list, with a nonzero machine id.
   task automatic test_id_filter;
      write_machine_id(32'hC0DE_5EED);
      send_section(40, $urandom, 8'd2, 32'd4, 1, 0, -1);     // listed
      send_section(40, $urandom, 8'd2, 32'd1, 2, 0, -1);     // past the count
      send_section(40, $urandom, 8'd3, '1, -1, 0, -1);       // not listed
      send_section(40, $urandom, 8'd3, 32'd4, 3, 0, -1);
      send_section(40, $urandom, 8'd4, 32'd4, 0, 0, -1);     // excluded
      send_section(40, $urandom, 8'd4, 32'd4, -1, 0, -1);
      send_section(40, $urandom, 8'd1, 32'd4, -1, 0, -1);    // broadcast type
      send_section(40, $urandom, 8'd200, '0, 0, 0, -1);      // empty list
      send_section(40, $urandom, 8'd2, 32'd4, 1, 1, -1);     // listed, bad CRC
   endtask

   // Entry id bytes that reach into the CRC are not compared.
   task automatic test_entries_near_crc;
      send_section(29, $urandom, 8'd2, '1, 2, 0, -1);
      send_section(30, $urandom, 8'd2, '1, 2, 0, -1);
      send_section(31, $urandom, 8'd2, '1, 2, 0, -1);        // last one fits
      send_section(30, $urandom, 8'd4, '1, 2, 0, -1);
   endtask

   // Longest legal length opens a section; the next start abandons it.
   task automatic test_longest_section;
      send_section(4093, $urandom, 8'd2, '1, 800, 0, 40);
   endtask

   // Result side holds off while short sections keep coming.
   task automatic test_backpressure;
      drain_results();
      no_gaps      = 1'b1;
      hold_request = 1'b1;
      repeat (8) send_section($urandom_range(12, 4), $urandom,
                              TYPE_W'($urandom_range(5)), '0, -1, 0, -1);
      no_gaps = 1'b0;
   endtask

   task automatic test_random_phase(input logic [WORD_W-1:0] id, input bit calm);
      int start;
      int r;
      write_machine_id(id);
      no_gaps = calm;
      start   = bytes_sent - stray_bytes;
      while (bytes_sent - stray_bytes - start < PHASE_BYTES) begin
         r = $urandom_range(99);
         if (r < 82) begin
            random_section(1'b0);
         end else if (r < 90) begin
            random_section(1'b1);
         end else if (r < 95) begin
            send_bad_header($urandom_range(1) ? LEN_W'($urandom_range(3))
                                              : LEN_W'($urandom_range(4095, 4094)),
                            $urandom_range(3));
         end else begin
            r = $urandom_range(4, 1);
            stray_bytes += r;
            repeat (r) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset                <= 1'b1;
      push                 <= 1'b0;
      req_section_byte     <= '0;
      req_start_of_section <= 1'b0;
      csr_valid            <= 1'b0;
      csr_machine_id       <= '0;
      rx_machine_id         = '0;
      sticky_hit            = 1'b0;
      sec_open              = 1'b0;
      clear_section_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_section_rules();
      test_id_filter();
      test_entries_near_crc();
      test_longest_section();
      test_backpressure();
      test_random_phase('1, 1'b0);
      test_random_phase('0, 1'b1);          // back-to-back on both sides
      test_random_phase($urandom, 1'b0);
      test_random_phase(32'h0000_0001, 1'b0);
      test_random_phase($urandom, 1'b0);
      drain_results();

      $display("Covered %0d sections in %0d byte transfers, %0d results checked, %0d id writes",
               sections_sent, bytes_sent, results_checked, config_writes);
      $display("Input stalled %0d cycles, %0d long output hold-offs",
               stall_cycles, holds_done);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/nsf_pkg.sv
hdl/nsf_front.sv
hdl/nsf_cmd_queue.sv
hdl/nsf_back.sv
hdl/notify_section_filter.sv
tb/notify_section_filter_test.sv
